// ===== design/hcbp_pkg.sv =====
`timescale 1ns / 1ps
package hcbp_pkg;

  localparam int MaxCodeLenDefault = 32;
  localparam int SymbolCountDefault = 256;

  localparam int ActionW = 2;
  localparam int SymbolW = 8;
  localparam int CodeWordW = 32;
  localparam int CodeLenW = 6;
  localparam int ByteW = 8;
  localparam int PendW = 7;
  localparam int PendCntW = 3;
  localparam int AccW = CodeWordW + ByteW;
  localparam int AccCntW = 7;
  localparam int EntryW = CodeWordW + CodeLenW;

  localparam logic [ActionW-1:0] ActLoad = 2'd0;
  localparam logic [ActionW-1:0] ActEncode = 2'd1;
  localparam logic [ActionW-1:0] ActFlush = 2'd2;

  typedef struct packed {
    logic [CodeWordW-1:0] word;
    logic [CodeLenW-1:0]  len;
  } code_entry_t;

  typedef struct packed {
    logic enc_start;
    logic flush_start;
  } pack_cmd_t;

  typedef struct packed {
    logic busy;
  } pack_stat_t;

  typedef enum logic [1:0] {
    CtrlIdle,
    CtrlLookup,
    CtrlWait
  } ctrl_state_t;

endpackage

// ===== design/hcbp_ifs.sv =====
`timescale 1ns / 1ps
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ActionW-1:0]   action;
  logic [SymbolW-1:0]   symbol;
  logic [CodeWordW-1:0] code_word;
  logic [CodeLenW-1:0]  code_length;

  modport source (output valid, action, symbol, code_word, code_length, input ready);
  modport sink (input valid, action, symbol, code_word, code_length, output ready);
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packed_byte;
  logic             padded;
  logic             last_of_run;

  modport source (output valid, packed_byte, padded, last_of_run, input ready);
  modport sink (input valid, packed_byte, padded, last_of_run, output ready);
endinterface

// ===== design/hcbp_ram.sv =====
`timescale 1ns / 1ps
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/hcbp_ctrl.sv =====
`timescale 1ns / 1ps
module hcbp_ctrl #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDefault,
  parameter int SYMBOL_COUNT = hcbp_pkg::SymbolCountDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  hcbp_in_if.sink                         request,
  output logic                            ram_we,
  output logic [$clog2(SYMBOL_COUNT)-1:0] ram_waddr,
  output logic [hcbp_pkg::EntryW-1:0]     ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(SYMBOL_COUNT)-1:0] ram_raddr,
  output hcbp_pkg::pack_cmd_t             cmd,
  input  hcbp_pkg::pack_stat_t            stat
);
  import hcbp_pkg::*;

  localparam int AddrW = $clog2(SYMBOL_COUNT);
  localparam int LenLimitInt = (MAX_CODE_LEN < CodeWordW) ? MAX_CODE_LEN : CodeWordW;
  localparam logic [CodeLenW:0] LenLimit = (CodeLenW + 1)'(LenLimitInt);
  localparam logic [SymbolW:0] SymLimit = (SymbolW + 1)'(SYMBOL_COUNT);

  ctrl_state_t state, state_next;
  logic sym_ok;
  logic len_ok;
  logic [CodeWordW-1:0] word_mask;
  code_entry_t entry;

  assign sym_ok = {1'b0, request.symbol} < SymLimit;
  assign len_ok = {1'b0, request.code_length} <= LenLimit;
  assign word_mask = (request.code_length >= CodeLenW'(CodeWordW)) ? '1 :
                     ~({CodeWordW{1'b1}} << request.code_length);

  always_comb begin
    entry.word = request.code_word & word_mask;
    entry.len = request.code_length;
  end

  assign ram_wdata = entry;
  assign ram_waddr = request.symbol[AddrW-1:0];
  assign ram_raddr = request.symbol[AddrW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CtrlIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    request.ready = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    cmd = '0;
    unique case (state)
      CtrlIdle: begin
        request.ready = 1'b1;
        if (request.valid) begin
          unique case (request.action)
            ActLoad: begin
              ram_we = sym_ok && len_ok;
            end
            ActEncode: begin
              if (sym_ok) begin
                ram_re = 1'b1;
                state_next = CtrlLookup;
              end
            end
            ActFlush: begin
              cmd.flush_start = 1'b1;
              state_next = CtrlWait;
            end
            default: begin
            end
          endcase
        end
      end
      CtrlLookup: begin
        cmd.enc_start = 1'b1;
        state_next = CtrlWait;
      end
      CtrlWait: begin
        if (!stat.busy) begin
          state_next = CtrlIdle;
        end
      end
      default: begin
        state_next = CtrlIdle;
      end
    endcase
  end

endmodule

// ===== design/hcbp_packer.sv =====
`timescale 1ns / 1ps
module hcbp_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  hcbp_pkg::pack_cmd_t         cmd,
  input  logic [hcbp_pkg::EntryW-1:0] entry_bits,
  output hcbp_pkg::pack_stat_t        stat,
  hcbp_out_if.source                  result
);
  import hcbp_pkg::*;

  code_entry_t entry;
  logic busy;
  logic flush_mode;
  logic [AccW-1:0] acc;
  logic [AccCntW-1:0] cnt;
  logic [PendW-1:0] pend;
  logic [PendCntW-1:0] pcount;
  logic [AccW-1:0] code_left;
  logic [AccW-1:0] pend_left;
  logic emit_ok;
  logic slot_free;
  logic emit;

  assign entry = entry_bits;
  assign stat.busy = busy;
  assign code_left = {entry.word, {ByteW{1'b0}}} << (CodeLenW'(CodeWordW) - entry.len);
  assign pend_left = {pend, {(AccW - PendW){1'b0}}};
  assign emit_ok = (cnt >= AccCntW'(ByteW)) || (flush_mode && (cnt != '0));
  assign slot_free = !result.valid || result.ready;
  assign emit = busy && !cmd.enc_start && !cmd.flush_start && emit_ok && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      flush_mode <= 1'b0;
      cnt <= '0;
      pend <= '0;
      pcount <= '0;
      result.valid <= 1'b0;
    end else begin
      if (emit) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (cmd.enc_start) begin
        acc <= pend_left | (code_left >> pcount);
        cnt <= AccCntW'(pcount) + AccCntW'(entry.len);
        flush_mode <= 1'b0;
        busy <= 1'b1;
      end else if (cmd.flush_start) begin
        acc <= pend_left;
        cnt <= AccCntW'(pcount);
        flush_mode <= 1'b1;
        busy <= 1'b1;
      end else if (busy) begin
        if (emit_ok) begin
          if (slot_free) begin
            result.packed_byte <= acc[AccW-1 -: ByteW];
            result.padded <= flush_mode;
            result.last_of_run <= flush_mode || (cnt < AccCntW'(2 * ByteW));
            acc <= acc << ByteW;
            cnt <= flush_mode ? '0 : cnt - AccCntW'(ByteW);
          end
        end else begin
          busy <= 1'b0;
          pend <= flush_mode ? '0 : acc[AccW-1 -: PendW];
          pcount <= flush_mode ? '0 : cnt[PendCntW-1:0];
        end
      end
    end
  end

endmodule

// ===== design/huffman_code_bit_packer_top.sv =====
`timescale 1ns / 1ps
// Huffman bit packer with a code table of SYMBOL_COUNT entries held in a
// synchronous RAM. A load request writes one entry, and a load whose length
// exceeds MAX_CODE_LEN or 32 is dropped. An encode request reads the table,
// merges the code behind the pending bits, and emits one byte per cycle from
// the packing register while the result side accepts. It holds off the input
// until its bytes are out. A flush request emits the leftover bits, zero
// padded at the low end.
module huffman_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MaxCodeLenDefault,
  parameter int SYMBOL_COUNT = hcbp_pkg::SymbolCountDefault
) (
  input logic        clk,
  input logic        rst,
  hcbp_in_if.sink    request,
  hcbp_out_if.source result
);
  import hcbp_pkg::*;

  localparam int AddrW = $clog2(SYMBOL_COUNT);

  logic ram_we;
  logic ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;
  pack_cmd_t cmd;
  pack_stat_t stat;

  hcbp_ctrl #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .request(request),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re(ram_re),
    .ram_raddr(ram_raddr),
    .cmd(cmd),
    .stat(stat)
  );

  hcbp_ram #(
    .WIDTH(EntryW),
    .DEPTH(SYMBOL_COUNT)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hcbp_packer u_packer (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .entry_bits(ram_rdata),
    .stat(stat),
    .result(result)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import hcbp_pkg::*;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;
  localparam int MaxLen = MaxCodeLenDefault;
  localparam int RandomRequests = 100;
  localparam int DrainCycles = 10;
  localparam int TailCycles = 50;

  typedef struct packed {
    logic [ActionW-1:0]   action;
    logic [SymbolW-1:0]   symbol;
    logic [CodeWordW-1:0] code_word;
    logic [CodeLenW-1:0]  code_length;
  } pack_req_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             padded;
    logic             last;
  } out_byte_t;

  typedef struct packed {
    pack_req_t   req;
    logic        typed;
    logic [2:0]  count;
    logic [31:0] bytes;
    logic        pad;
  } dir_row_t;

  localparam int DirCount = 25;
  localparam dir_row_t DirRows [DirCount] = '{
    '{'{ActFlush, 8'd0, 32'h0000_0000, 6'd0}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActUnused, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd0, 32'hFFFF_FFFF, 6'd0}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd1, 32'h0000_00A5, 6'd8}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd255, 32'hFFFF_FFFF, 6'd32}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd2, 32'hFFFF_FFF5, 6'd3}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd3, 32'h0000_0000, 6'd1}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd1, 32'h0000_0000, 6'd33}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd255, 32'h0000_0000, 6'd63}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd1, 32'h0000_0000, 6'd0}, 1'b1, 3'd1, 32'hA500_0000, 1'b0},
    '{'{ActEncode, 8'd255, 32'h0000_0000, 6'd0}, 1'b1, 3'd4, 32'hFFFF_FFFF, 1'b0},
    '{'{ActEncode, 8'd0, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd2, 32'h0000_0000, 6'd0}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActFlush, 8'd0, 32'h0000_0000, 6'd0}, 1'b1, 3'd1, 32'hA000_0000, 1'b1},
    '{'{ActFlush, 8'hFF, 32'hFFFF_FFFF, 6'd63}, 1'b1, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd2, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd1, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd3, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd255, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd128, 32'h0000_0155, 6'd9}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd128, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActUnused, 8'd0, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActFlush, 8'd0, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActLoad, 8'd127, 32'h8000_0000, 6'd32}, 1'b0, 3'd0, 32'h0000_0000, 1'b0},
    '{'{ActEncode, 8'd127, 32'h0000_0000, 6'd0}, 1'b0, 3'd0, 32'h0000_0000, 1'b0}
  };

  logic clk;
  logic rst;

  hcbp_in_if req_if();
  hcbp_out_if res_if();

  huffman_code_bit_packer_top dut (
    .clk(clk),
    .rst(rst),
    .request(req_if.sink),
    .result(res_if.source)
  );

  logic [CodeWordW-1:0] tbl_word [SymbolCountDefault];
  logic [CodeLenW-1:0]  tbl_len [SymbolCountDefault];
  bit                   tbl_written [SymbolCountDefault];
  logic [SymbolW-1:0]   written_syms [$];
  logic [ByteW-1:0]     pend_bits;
  int                   pend_cnt;

  out_byte_t expected_bytes [$];
  int mismatches;
  int n_load, n_encode, n_flush, n_other, n_checked;
  int source_calm, sink_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d bytes still expected.", expected_bytes.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic int idle_len(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8: return $urandom_range(1, 3);
      default: return $urandom_range(8, 25);
    endcase
  endfunction

  // Updates the code table and bit buffer for one request and returns the
  // bytes that it emits.
  function automatic void pack_request(input pack_req_t r, ref out_byte_t run [$]);
    logic [CodeWordW-1:0] code;
    int len;
    run.delete();
    case (r.action)
      ActLoad: begin
        n_load++;
        if (r.code_length <= MaxLen && r.code_length <= CodeWordW) begin
          tbl_word[r.symbol] = r.code_word & (32'hFFFF_FFFF >> (CodeWordW - r.code_length));
          tbl_len[r.symbol] = r.code_length;
          if (!tbl_written[r.symbol]) begin
            tbl_written[r.symbol] = 1'b1;
            written_syms.push_back(r.symbol);
          end
        end
      end
      ActEncode: begin
        n_encode++;
        code = tbl_word[r.symbol];
        len = int'(tbl_len[r.symbol]);
        for (int i = len; i > 0; i--) begin
          pend_bits = {pend_bits[ByteW-2:0], code[i-1]};
          pend_cnt++;
          if (pend_cnt == ByteW) begin
            run.push_back('{pend_bits, 1'b0, 1'b0});
            pend_bits = '0;
            pend_cnt = 0;
          end
        end
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
      end
      ActFlush: begin
        n_flush++;
        if (pend_cnt > 0) run.push_back('{pend_bits << (ByteW - pend_cnt), 1'b1, 1'b1});
        pend_bits = '0;
        pend_cnt = 0;
      end
      default: n_other++;
    endcase
  endfunction

  task automatic drive_request(input pack_req_t r, input bit drain);
    int gap;
    gap = idle_len(source_calm);
    if (gap > 0 || drain) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
      end
    end
    req_if.valid <= 1'b1;
    req_if.action <= r.action;
    req_if.symbol <= r.symbol;
    req_if.code_word <= r.code_word;
    req_if.code_length <= r.code_length;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  function automatic pack_req_t random_request();
    pack_req_t r;
    int pick;
    r.symbol = SymbolW'($urandom_range(0, 255));
    r.code_word = $urandom;
    r.code_length = CodeLenW'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      r.action = ActLoad;
      case ($urandom_range(0, 19))
        0: r.code_length = '0;
        1, 2: r.code_length = CodeLenW'($urandom_range(33, 63));
        3, 4, 5: r.code_length = CodeLenW'($urandom_range(11, 32));
        default: r.code_length = CodeLenW'($urandom_range(1, 10));
      endcase
    end else if (pick < 80) begin
      r.action = ActEncode;
      r.symbol = written_syms[$urandom_range(0, written_syms.size() - 1)];
    end else if (pick < 93) begin
      r.action = ActFlush;
    end else begin
      r.action = ActUnused;
    end
    return r;
  endfunction

  initial begin
    int stall_left;
    out_byte_t want;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) begin
        n_checked++;
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected byte %02h padded=%0b last=%0b at %0t.",
                     res_if.packed_byte, res_if.padded, res_if.last_of_run, $realtime);
        end else begin
          want = expected_bytes.pop_front();
          if (res_if.packed_byte !== want.data || res_if.padded !== want.padded ||
              res_if.last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Byte mismatch at %0t: expected %02h/%0b/%0b, got %02h/%0b/%0b.",
                       $realtime, want.data, want.padded, want.last,
                       res_if.packed_byte, res_if.padded, res_if.last_of_run);
          end
        end
      end
      if (stall_left == 0) stall_left = idle_len(sink_calm);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    out_byte_t run [$];
    pack_req_t r;
    int done;
    mismatches = 0;
    pend_bits = '0;
    pend_cnt = 0;
    source_calm = 0;
    sink_calm = 0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.action <= ActLoad;
    req_if.symbol <= '0;
    req_if.code_word <= '0;
    req_if.code_length <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Rows with typed bytes replace the prediction, but the predictor still
    // runs so that the table and buffer stay in step.
    for (int i = 0; i < DirCount; i++) begin
      drive_request(DirRows[i].req, 1'b0);
      pack_request(DirRows[i].req, run);
      if (DirRows[i].typed) begin
        run.delete();
        for (int k = 0; k < DirRows[i].count; k++)
          run.push_back('{DirRows[i].bytes[31-8*k -: 8], DirRows[i].pad,
                          k == DirRows[i].count - 1});
      end
      foreach (run[j]) expected_bytes.push_back(run[j]);
    end

    done = 0;
    while (done < RandomRequests) begin
      r = random_request();
      drive_request(r, done == 0 || $urandom_range(0, 29) == 0);
      pack_request(r, run);
      foreach (run[j]) expected_bytes.push_back(run[j]);
      if (r.action != ActUnused) done++;
    end
    req_if.valid <= 1'b0;

    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("Requests: %0d loads, %0d encodes, %0d flushes, %0d unused actions.",
             n_load, n_encode, n_flush, n_other);
    $display("Checked %0d packed bytes with %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
